// ===== hw/rtl/ims_pkg.sv =====
package ims_pkg;

  localparam int unsigned VAR_BITS    = 8;
  localparam int unsigned GROUP_DEPTH = 8;

  localparam int unsigned TermW = 8;
  localparam int unsigned IdxW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(GROUP_DEPTH + 1);

  localparam logic [TermW-1:0] TermBitsMask =
      TermW'(((64'd1 << VAR_BITS) - 64'd1) & 64'hFF);
  localparam logic [CntW-1:0]  GroupFull    = CntW'(GROUP_DEPTH);

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [2:0] {
    OP_LOAD_A  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_COMBINE = 3'd2,
    OP_EMIT    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_MERGED   = 2'd0,
    KIND_UNMERGED = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMB,
    S_EMIT,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear;
    logic scan_init;
    logic comb_step;
    logic emit_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic comb_hit;
    logic emit_hit;
    logic comb_end;
    logic emit_end;
    logic comb_empty;
    logic emit_empty;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/ims_ctrl.sv =====
module ims_ctrl import ims_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  logic    [2:0] op_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   stall_comb, stall_emit;

  assign stall_comb = status_i.comb_hit && status_i.pend_valid && !status_i.out_free;
  assign stall_emit = status_i.emit_hit && status_i.pend_valid && !status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (op_i)
            OP_LOAD_A: begin
              cmd_o.load_a = 1'b1;
              state_d      = S_FLUSH;
            end
            OP_LOAD_B: begin
              cmd_o.load_b = 1'b1;
              state_d      = S_FLUSH;
            end
            OP_COMBINE: begin
              cmd_o.scan_init = 1'b1;
              if (!status_i.comb_empty) state_d = S_COMB;
            end
            OP_EMIT: begin
              cmd_o.scan_init = 1'b1;
              if (!status_i.emit_empty) state_d = S_EMIT;
            end
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_COMB: begin
        if (!stall_comb) begin
          cmd_o.comb_step = 1'b1;
          if (status_i.comb_end) state_d = S_FLUSH;
        end
      end
      S_EMIT: begin
        if (!stall_emit) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_end) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !status_i.pend_valid)
    else $error("pending result left over in idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |-> status_i.out_free && status_i.pend_valid)
    else $error("flush without room or without pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) && !status_i.pend_valid |=> state_q == S_IDLE)
    else $error("flush state not left");

endmodule

// ===== hw/rtl/ims_dpath.sv =====
module ims_dpath import ims_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  s_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o,
  output logic [1:0]          m_kind_o,
  output logic                m_last_o
);

  logic [TermW-1:0] a_val_q [GROUP_DEPTH];
  logic [TermW-1:0] a_msk_q [GROUP_DEPTH];
  logic [TermW-1:0] b_val_q [GROUP_DEPTH];
  logic [TermW-1:0] b_msk_q [GROUP_DEPTH];
  logic [GROUP_DEPTH-1:0] a_mrg_q, a_mrg_d, b_mrg_q, b_mrg_d;
  logic [CntW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;

  logic             pend_valid_q, pend_valid_d;
  logic [1:0]       pend_kind_q;
  logic [TermW-1:0] pend_value_q, pend_mask_q;
  logic             pend_ovf_q;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_kind_q;
  logic [TermW-1:0] out_value_q, out_mask_q;
  logic             out_ovf_q, out_last_q;

  logic [TermW-1:0] in_mask, in_value;
  logic [TermW-1:0] ea_val, ea_msk, eb_val, eb_msk, diff;
  logic             a_full, b_full, comb_hit, emit_hit, j_end, i_end;
  logic             found, pend_load, push_out, out_free;
  logic [1:0]       cand_kind;
  logic [TermW-1:0] cand_value, cand_mask;
  logic             cand_ovf;

  assign in_mask  = s_data_i[15:8] & TermBitsMask;
  assign in_value = s_data_i[7:0] & TermBitsMask & ~in_mask;

  assign ea_val = a_val_q[i_q];
  assign ea_msk = a_msk_q[i_q];
  assign eb_val = b_val_q[j_q];
  assign eb_msk = b_msk_q[j_q];
  assign diff   = ea_val ^ eb_val;

  assign a_full   = (a_cnt_q == GroupFull);
  assign b_full   = (b_cnt_q == GroupFull);
  assign comb_hit = (ea_msk == eb_msk) && $onehot(diff);
  assign emit_hit = !a_mrg_q[i_q];
  assign i_end    = (CntW'(i_q) == a_cnt_q - CntW'(1));
  assign j_end    = (CntW'(j_q) == b_cnt_q - CntW'(1));
  assign out_free = !out_valid_q || m_ready_i;

  assign found     = (cmd_i.comb_step && comb_hit) || (cmd_i.emit_step && emit_hit);
  assign pend_load = cmd_i.load_a || cmd_i.load_b || found;
  assign push_out  = (found && pend_valid_q) || cmd_i.flush;

  always_comb begin
    priority if (cmd_i.load_a || cmd_i.load_b) begin
      cand_kind  = KIND_STATUS;
      cand_value = in_value;
      cand_mask  = in_mask;
      cand_ovf   = cmd_i.load_a ? a_full : b_full;
    end else if (cmd_i.comb_step) begin
      cand_kind  = KIND_MERGED;
      cand_value = ea_val & eb_val;
      cand_mask  = ea_msk | diff;
      cand_ovf   = 1'b0;
    end else begin
      cand_kind  = KIND_UNMERGED;
      cand_value = ea_val;
      cand_mask  = ea_msk;
      cand_ovf   = 1'b0;
    end
  end

  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    a_mrg_d = a_mrg_q;
    b_mrg_d = b_mrg_q;
    i_d     = i_q;
    j_d     = j_q;
    if (cmd_i.clear) begin
      a_cnt_d = '0;
      b_cnt_d = '0;
      a_mrg_d = '0;
      b_mrg_d = '0;
    end
    if (cmd_i.load_a && !a_full) begin
      a_mrg_d[a_cnt_q[IdxW-1:0]] = 1'b0;
      a_cnt_d                    = a_cnt_q + CntW'(1);
    end
    if (cmd_i.load_b && !b_full) begin
      b_mrg_d[b_cnt_q[IdxW-1:0]] = 1'b0;
      b_cnt_d                    = b_cnt_q + CntW'(1);
    end
    if (cmd_i.scan_init) begin
      i_d = '0;
      j_d = '0;
    end
    if (cmd_i.comb_step) begin
      if (comb_hit) begin
        a_mrg_d[i_q] = 1'b1;
        b_mrg_d[j_q] = 1'b1;
      end
      if (j_end) begin
        j_d = '0;
        i_d = i_q + IdxW'(1);
      end else begin
        j_d = j_q + IdxW'(1);
      end
    end
    if (cmd_i.emit_step) begin
      i_d = i_q + IdxW'(1);
    end
    pend_valid_d = pend_load ? 1'b1 : (cmd_i.flush ? 1'b0 : pend_valid_q);
    out_valid_d  = push_out ? 1'b1 : (out_valid_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q      <= '0;
      b_cnt_q      <= '0;
      a_mrg_q      <= '0;
      b_mrg_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      a_cnt_q      <= a_cnt_d;
      b_cnt_q      <= b_cnt_d;
      a_mrg_q      <= a_mrg_d;
      b_mrg_q      <= b_mrg_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !a_full) begin
      a_val_q[a_cnt_q[IdxW-1:0]] <= in_value;
      a_msk_q[a_cnt_q[IdxW-1:0]] <= in_mask;
    end
    if (cmd_i.load_b && !b_full) begin
      b_val_q[b_cnt_q[IdxW-1:0]] <= in_value;
      b_msk_q[b_cnt_q[IdxW-1:0]] <= in_mask;
    end
    if (pend_load) begin
      pend_kind_q  <= cand_kind;
      pend_value_q <= cand_value;
      pend_mask_q  <= cand_mask;
      pend_ovf_q   <= cand_ovf;
    end
    if (push_out) begin
      out_kind_q  <= pend_kind_q;
      out_value_q <= pend_value_q;
      out_mask_q  <= pend_mask_q;
      out_ovf_q   <= pend_ovf_q;
      out_last_q  <= cmd_i.flush;
    end
  end

  assign status_o.comb_hit   = comb_hit;
  assign status_o.emit_hit   = emit_hit;
  assign status_o.comb_end   = i_end && j_end;
  assign status_o.emit_end   = i_end;
  assign status_o.comb_empty = (a_cnt_q == '0) || (b_cnt_q == '0);
  assign status_o.emit_empty = (a_cnt_q == '0);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign m_valid_o = out_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {7'd0, out_ovf_q, out_mask_q, out_value_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= GroupFull && b_cnt_q <= GroupFull)
    else $error("group count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_out |-> out_free)
    else $error("output register overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found && pend_valid_q |=> out_valid_q && !out_last_q)
    else $error("intermediate result not forwarded");

endmodule

// ===== hw/rtl/implicant_merge_step.sv =====
// implicant merge step: one combining round between two implicant groups
// input stream: s_axis_tuser carries the operation (load A, load B,
// combine, emit unmerged A, clear), s_axis_tdata the term value and mask
// output stream: m_axis_tuser carries the result kind, m_axis_tlast marks
// the final result of an operation, m_axis_tdata value, mask and overflow
// one operation is in flight at a time; s_axis_tready is high only when
// the block is idle
// a load returns its status result through the pending and output registers
// a combine walks every A/B pair through the entry comparator, one pair per
// cycle unless a hit is held back by a full output register
// an emit walks group A, one entry per cycle unless a hit is held back likewise
// clear returns nothing
// a found result waits in a pending register until the next one shows up
// or the walk ends, so last can be set; a stalled receiver holds the walk
// at the next hit while the output register is full
// reset empties both groups and clears all merged marks; stored terms are
// not cleared since only entries below each group count are ever read
module implicant_merge_step import ims_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // term_value, term_mask
  input  logic [2:0]          s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_value, out_mask, overflow
  output logic [1:0]          m_axis_tuser,   // kind
  output logic                m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  ims_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  ims_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_data_i  (s_axis_tdata),
    .cmd_i     (cmd),
    .status_o  (status),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import ims_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomItems = 185;

  typedef struct packed {
    kind_e           kind;
    logic [TermW-1:0] value;
    logic [TermW-1:0] mask;
    logic            ovf;
    logic            last;
  } term_rec_t;

  class merge_tracker;
    logic [TermW-1:0] a_val [GROUP_DEPTH];
    logic [TermW-1:0] a_msk [GROUP_DEPTH];
    bit               a_hit [GROUP_DEPTH];
    int unsigned      a_cnt;
    logic [TermW-1:0] b_val [GROUP_DEPTH];
    logic [TermW-1:0] b_msk [GROUP_DEPTH];
    bit               b_hit [GROUP_DEPTH];
    int unsigned      b_cnt;
    term_rec_t        awaited [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      merges;
    int unsigned      overflows;

    function new();
      a_cnt = 0;
      b_cnt = 0;
      errors = 0;
      checked = 0;
      merges = 0;
      overflows = 0;
      for (int k = 0; k < GROUP_DEPTH; k++) begin
        a_hit[k] = 1'b0;
        b_hit[k] = 1'b0;
      end
    endfunction

    function void push_term(kind_e kind, logic [TermW-1:0] v, logic [TermW-1:0] m, logic ovf);
      term_rec_t rec;
      rec.kind = kind;
      rec.value = v;
      rec.mask = m;
      rec.ovf = ovf;
      rec.last = 1'b0;
      awaited = {awaited, rec};
    endfunction

    // works out the results of one accepted transfer
    function void absorb_item(logic [2:0] op, logic [InDataW-1:0] data);
      logic [TermW-1:0] m;
      logic [TermW-1:0] v;
      logic [TermW-1:0] diff;
      int unsigned      start;
      m = data[15:8] & TermBitsMask;
      v = data[7:0] & TermBitsMask & ~m;
      start = awaited.size();
      case (op)
        OP_LOAD_A: begin
          if (a_cnt < GROUP_DEPTH) begin
            a_val[a_cnt] = v;
            a_msk[a_cnt] = m;
            a_hit[a_cnt] = 1'b0;
            a_cnt++;
            push_term(KIND_STATUS, v, m, 1'b0);
          end else begin
            overflows++;
            push_term(KIND_STATUS, v, m, 1'b1);
          end
        end
        OP_LOAD_B: begin
          if (b_cnt < GROUP_DEPTH) begin
            b_val[b_cnt] = v;
            b_msk[b_cnt] = m;
            b_hit[b_cnt] = 1'b0;
            b_cnt++;
            push_term(KIND_STATUS, v, m, 1'b0);
          end else begin
            overflows++;
            push_term(KIND_STATUS, v, m, 1'b1);
          end
        end
        OP_COMBINE: begin
          for (int i = 0; i < a_cnt; i++) begin
            for (int j = 0; j < b_cnt; j++) begin
              diff = a_val[i] ^ b_val[j];
              if (a_msk[i] == b_msk[j] && $countones(diff) == 1) begin
                push_term(KIND_MERGED, a_val[i] & b_val[j], a_msk[i] | diff, 1'b0);
                a_hit[i] = 1'b1;
                b_hit[j] = 1'b1;
                merges++;
              end
            end
          end
        end
        OP_EMIT: begin
          for (int i = 0; i < a_cnt; i++) begin
            if (!a_hit[i]) push_term(KIND_UNMERGED, a_val[i], a_msk[i], 1'b0);
          end
        end
        OP_CLEAR: begin
          a_cnt = 0;
          b_cnt = 0;
          for (int k = 0; k < GROUP_DEPTH; k++) begin
            a_hit[k] = 1'b0;
            b_hit[k] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (awaited.size() > start) awaited[awaited.size()-1].last = 1'b1;
    endfunction

    function void match_result(logic [1:0] kind, logic [OutDataW-1:0] data, logic last);
      term_rec_t exp;
      term_rec_t act;
      act.kind = kind_e'(kind);
      act.value = data[7:0];
      act.mask = data[15:8];
      act.ovf = data[16];
      act.last = last;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual kind %0d value %h mask %h ovf %b last %b",
                 $time, act.kind, act.value, act.mask, act.ovf, act.last);
        return;
      end
      exp = awaited.pop_front();
      if (exp != act) begin
        errors++;
        $display("%0t: mismatch, expected kind %0d value %h mask %h ovf %b last %b",
                 $time, exp.kind, exp.value, exp.mask, exp.ovf, exp.last);
        $display("%0t: mismatch, actual   kind %0d value %h mask %h ovf %b last %b",
                 $time, act.kind, act.value, act.mask, act.ovf, act.last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  merge_tracker board;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  live_items = 0;
  bit           hold_request = 1'b0;

  implicant_merge_step uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               board.awaited.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.match_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // receiver: stall pattern is picked at random from four modes, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned hold_left;
    mode = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (cycle_count % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((cycle_count / 7) % 2 == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [TermW-1:0] v, logic [TermW-1:0] m);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {m, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.absorb_item(op, {m, v});
    if (op <= OP_CLEAR) live_items++;
    burst_left--;
  endtask

  task automatic send_op(logic [2:0] op);
    send_item(op, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (board.awaited.size() != 0);
    repeat (70) @(posedge clk_i);
  endtask

  // one combining round: well-formed most of the time, noise otherwise
  task automatic run_round();
    logic [TermW-1:0] sent_v [GROUP_DEPTH];
    logic [TermW-1:0] sent_m [GROUP_DEPTH];
    logic [TermW-1:0] round_mask;
    logic [TermW-1:0] m;
    logic [TermW-1:0] v;
    int unsigned      n_a;
    int unsigned      n_b;
    int unsigned      pick;
    int unsigned      bit_pos;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 2) == 0) send_op(3'($urandom_range(5, 7)));
        else send_op(3'($urandom_range(0, 4)));
      end
      return;
    end
    if ($urandom_range(0, 7) != 0) send_op(OP_CLEAR);
    round_mask = ($urandom_range(0, 1) == 1) ? 8'($urandom()) : 8'h00;
    n_a = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 5);
    n_b = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 5);
    for (int k = 0; k < n_a; k++) begin
      m = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : round_mask;
      v = 8'($urandom());
      if (k < GROUP_DEPTH) begin
        sent_m[k] = m & TermBitsMask;
        sent_v[k] = v & TermBitsMask & ~sent_m[k];
      end
      send_item(OP_LOAD_A, v, m);
    end
    for (int k = 0; k < n_b; k++) begin
      if (n_a > 0 && $urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, ((n_a < GROUP_DEPTH) ? n_a : GROUP_DEPTH) - 1);
        m = sent_m[pick];
        bit_pos = $urandom_range(0, TermW - 1);
        for (int t = 0; t < 8 && m[bit_pos]; t++) bit_pos = $urandom_range(0, TermW - 1);
        v = sent_v[pick] ^ (8'h01 << bit_pos);
        v = v | (8'($urandom()) & m);
      end else begin
        m = ($urandom_range(0, 1) == 1) ? round_mask : 8'($urandom());
        v = 8'($urandom());
      end
      send_item(OP_LOAD_B, v, m);
    end
    if ($urandom_range(0, 4) == 0) send_op(OP_EMIT);
    send_op(OP_COMBINE);
    send_op(OP_EMIT);
    if ($urandom_range(0, 5) == 0) send_op(OP_COMBINE);
  endtask

  initial begin
    int unsigned rounds;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty groups give no merges and no unmerged terms
    send_op(OP_COMBINE);
    send_op(OP_EMIT);
    // full groups where every pair merges
    repeat (GROUP_DEPTH) send_item(OP_LOAD_A, 8'h00, 8'h00);
    repeat (GROUP_DEPTH) send_item(OP_LOAD_B, 8'h01, 8'h00);
    send_item(OP_LOAD_A, 8'hFF, 8'hFF);
    send_item(OP_LOAD_B, 8'hFF, 8'h00);
    send_op(OP_COMBINE);
    send_op(OP_EMIT);
    send_op(OP_CLEAR);
    send_item(OP_LOAD_A, 8'hFF, 8'h00);
    send_item(OP_LOAD_A, 8'hFF, 8'h55);
    send_item(OP_LOAD_B, 8'hFE, 8'h00);
    send_op(OP_COMBINE);
    send_op(OP_EMIT);
    send_op(3'd5);
    send_op(3'd7);
    wait_drained();

    live_items = 0;
    rounds = 0;
    while (live_items < RandomItems) begin
      if (rounds == 4) hold_request = 1'b1;
      if (rounds == 9) wait_drained();
      run_round();
      rounds++;
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.awaited.size() != 0);
    repeat (80) @(posedge clk_i);

    $display("ran %0d rounds and %0d random transfers: %0d results checked", rounds,
             live_items, board.checked);
    $display("%0d merged terms and %0d overflowed loads among them", board.merges,
             board.overflows);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected", board.errors,
               board.awaited.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ims_pkg.sv
hw/rtl/ims_ctrl.sv
hw/rtl/ims_dpath.sv
hw/rtl/implicant_merge_step.sv
dv/testbench.sv
